[sv/mcbs_pkg.sv]
// Package with shared widths, types and the format class decode for the mip chain sizer.
package mcbs_pkg;

  localparam int unsigned EXT_W       = 15;  // width and height field width
  localparam int unsigned DEP_W       = 12;  // depth field width
  localparam int unsigned CLS_W       = 4;   // format class field width
  localparam int unsigned CNT_IN_W    = 4;   // level count field width
  localparam int unsigned TOT_W       = 38;  // total byte count width
  localparam int unsigned PX_W        = 5;   // bytes per pixel or per block
  localparam int unsigned P1_W        = 2 * EXT_W;
  localparam int unsigned P2_W        = P1_W + PX_W;
  localparam int unsigned P3_W        = P2_W + DEP_W;

  localparam int unsigned MAX_LEVELS_DEF  = 15;
  localparam int unsigned EXTENT_BITS_DEF = 15;

  localparam logic [CLS_W-1:0] CLS_PX0     = CLS_W'(0);
  localparam logic [CLS_W-1:0] CLS_PX1     = CLS_W'(1);
  localparam logic [CLS_W-1:0] CLS_PX2     = CLS_W'(2);
  localparam logic [CLS_W-1:0] CLS_PX3     = CLS_W'(3);
  localparam logic [CLS_W-1:0] CLS_PX4     = CLS_W'(4);
  localparam logic [CLS_W-1:0] CLS_PX8     = CLS_W'(5);
  localparam logic [CLS_W-1:0] CLS_PX16    = CLS_W'(6);
  localparam logic [CLS_W-1:0] CLS_BLOCK8  = CLS_W'(7);
  localparam logic [CLS_W-1:0] CLS_BLOCK16 = CLS_W'(8);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } ctrl_state_e;

  typedef struct packed {
    logic load;   // take the new item into the extent registers
    logic issue;  // push the current level into the pipeline
  } dp_cmd_t;

  typedef struct packed {
    logic empty;  // no level left in flight
  } dp_sts_t;

  // Bytes per element: per pixel for plain and unknown classes, per 4x4 block for the block classes.
  function automatic logic [PX_W-1:0] elem_bytes(input logic [CLS_W-1:0] cls);
    logic [PX_W-1:0] b;
    unique case (cls)
      CLS_PX0:     b = PX_W'(0);
      CLS_PX1:     b = PX_W'(1);
      CLS_PX2:     b = PX_W'(2);
      CLS_PX3:     b = PX_W'(3);
      CLS_PX4:     b = PX_W'(4);
      CLS_PX8:     b = PX_W'(8);
      CLS_PX16:    b = PX_W'(16);
      CLS_BLOCK8:  b = PX_W'(8);
      CLS_BLOCK16: b = PX_W'(16);
      default:     b = PX_W'(4);
    endcase
    return b;
  endfunction

  function automatic logic is_block(input logic [CLS_W-1:0] cls);
    return (cls == CLS_BLOCK8) || (cls == CLS_BLOCK16);
  endfunction

endpackage

[sv/mcbs_datapath.sv]
// Datapath: extent registers, three-stage multiply pipeline and saturating accumulator.
module mcbs_datapath #(
  parameter int unsigned EXTENT_BITS = mcbs_pkg::EXTENT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mcbs_pkg::dp_cmd_t                 cmd_i,
  output mcbs_pkg::dp_sts_t                 sts_o,
  input  logic [mcbs_pkg::CLS_W-1:0]        format_class_i,
  input  logic [mcbs_pkg::EXT_W-1:0]        width_i,
  input  logic [mcbs_pkg::EXT_W-1:0]        height_i,
  input  logic [mcbs_pkg::DEP_W-1:0]        depth_i,
  output logic [mcbs_pkg::TOT_W-1:0]        total_bytes_o
);

  localparam int unsigned EW  = mcbs_pkg::EXT_W;
  localparam int unsigned DW  = mcbs_pkg::DEP_W;
  localparam int unsigned SW  = mcbs_pkg::P3_W + 1;

  logic [EW-1:0] ext_mask;
  logic [EW-1:0] w_q, w_d, h_q, h_d;
  logic [DW-1:0] d_q, d_d;
  logic [mcbs_pkg::PX_W-1:0] px_q;
  logic blk_q;

  logic [EW-1:0] ew, eh;
  logic [EW:0]   w_rnd, h_rnd;

  logic v1_q, v2_q, v3_q;
  logic [mcbs_pkg::P1_W-1:0] p1_q;
  logic [mcbs_pkg::P2_W-1:0] p2_q;
  logic [mcbs_pkg::P3_W-1:0] p3_q;
  logic [DW-1:0] d1_q, d2_q;
  logic [mcbs_pkg::TOT_W-1:0] acc_q, acc_d;
  logic [SW-1:0] sum;

  always_comb begin
    for (int i = 0; i < int'(EW); i++) begin
      ext_mask[i] = (i < int'(EXTENT_BITS));
    end
  end

  // Extents halve after every issued level but never drop below one.
  always_comb begin
    w_d = w_q;
    h_d = h_q;
    d_d = d_q;
    if (cmd_i.load) begin
      w_d = width_i & ext_mask;
      h_d = height_i & ext_mask;
      d_d = depth_i;
    end else if (cmd_i.issue) begin
      w_d = (w_q > EW'(1)) ? (w_q >> 1) : EW'(1);
      h_d = (h_q > EW'(1)) ? (h_q >> 1) : EW'(1);
      d_d = (d_q > DW'(1)) ? (d_q >> 1) : DW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    h_q <= h_d;
    d_q <= d_d;
    if (cmd_i.load) begin
      px_q  <= mcbs_pkg::elem_bytes(format_class_i);
      blk_q <= mcbs_pkg::is_block(format_class_i);
    end
  end

  // Block classes count whole 4x4 blocks.
  assign w_rnd = {1'b0, w_q} + (EW + 1)'(3);
  assign h_rnd = {1'b0, h_q} + (EW + 1)'(3);
  assign ew    = blk_q ? EW'(w_rnd >> 2) : w_q;
  assign eh    = blk_q ? EW'(h_rnd >> 2) : h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= mcbs_pkg::P1_W'(ew) * mcbs_pkg::P1_W'(eh);
    d1_q <= d_q;
    p2_q <= mcbs_pkg::P2_W'(p1_q) * mcbs_pkg::P2_W'(px_q);
    d2_q <= d1_q;
    p3_q <= mcbs_pkg::P3_W'(p2_q) * mcbs_pkg::P3_W'(d2_q);
  end

  // The running total saturates; all terms are non-negative so it stays there.
  assign sum = SW'(acc_q) + SW'(p3_q);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.load) begin
      acc_d = '0;
    end else if (v3_q) begin
      if (sum > SW'({mcbs_pkg::TOT_W{1'b1}})) begin
        acc_d = {mcbs_pkg::TOT_W{1'b1}};
      end else begin
        acc_d = sum[mcbs_pkg::TOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign sts_o.empty   = !(v1_q || v2_q || v3_q);
  assign total_bytes_o = acc_q;

endmodule

[sv/mcbs_ctrl.sv]
// Controller: takes an item, issues one level per cycle, waits for the pipeline to drain.
module mcbs_ctrl #(
  parameter int unsigned MAX_LEVELS = mcbs_pkg::MAX_LEVELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mcbs_pkg::CNT_IN_W-1:0]  level_count_i,
  output logic                           busy_o,
  output logic                           done_o,
  output mcbs_pkg::dp_cmd_t              cmd_o,
  input  mcbs_pkg::dp_sts_t              sts_i
);

  localparam int unsigned LVL_W = $clog2(MAX_LEVELS + 1);

  mcbs_pkg::ctrl_state_e state_q, state_d;
  logic [LVL_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcbs_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    busy_o    = 1'b1;
    done_o    = 1'b0;
    unique case (state_q)
      mcbs_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (int'(level_count_i) > int'(MAX_LEVELS)) begin
            cnt_d = LVL_W'(MAX_LEVELS);
          end else begin
            cnt_d = LVL_W'(level_count_i);
          end
          state_d = (level_count_i == '0) ? mcbs_pkg::ST_DRAIN : mcbs_pkg::ST_RUN;
        end
      end
      mcbs_pkg::ST_RUN: begin
        cmd_o.issue = 1'b1;
        cnt_d       = cnt_q - LVL_W'(1);
        if (cnt_q == LVL_W'(1)) begin
          state_d = mcbs_pkg::ST_DRAIN;
        end
      end
      mcbs_pkg::ST_DRAIN: begin
        if (sts_i.empty) begin
          done_o  = 1'b1;
          state_d = mcbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mcbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/mip_chain_byte_size.sv]
// Top level of the mip chain byte size calculator.
// An item is taken when start_i is high and busy_o is low. The block then
// steps through min(level_count, MAX_LEVELS) levels, one level entering a
// three-stage multiply pipeline per cycle. When the last level has passed the
// pipeline and the accumulator, done_o is high for exactly one cycle; the
// receiver cannot stall it. The total is then on total_bytes_o and stays there
// until the next item is taken. With a level count of zero, done_o is high in
// the cycle that follows the edge that takes the item. busy_o falls the cycle
// after done_o. Totals above 2^38-1 saturate.
module mip_chain_byte_size #(
  parameter int unsigned MAX_LEVELS  = mcbs_pkg::MAX_LEVELS_DEF,
  parameter int unsigned EXTENT_BITS = mcbs_pkg::EXTENT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  output logic                           done_o,
  input  logic [mcbs_pkg::CLS_W-1:0]     format_class_i,
  input  logic [mcbs_pkg::EXT_W-1:0]     width_i,
  input  logic [mcbs_pkg::EXT_W-1:0]     height_i,
  input  logic [mcbs_pkg::DEP_W-1:0]     depth_i,
  input  logic [mcbs_pkg::CNT_IN_W-1:0]  level_count_i,
  output logic [mcbs_pkg::TOT_W-1:0]     total_bytes_o
);

  mcbs_pkg::dp_cmd_t cmd;
  mcbs_pkg::dp_sts_t sts;

  mcbs_ctrl #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .level_count_i (level_count_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  mcbs_datapath #(
    .EXTENT_BITS(EXTENT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .format_class_i (format_class_i),
    .width_i        (width_i),
    .height_i       (height_i),
    .depth_i        (depth_i),
    .total_bytes_o  (total_bytes_o)
  );

endmodule
